// File: rtl/core/cosfd_pkg.sv
package cosfd_pkg;

    localparam int MOTOR_SLOTS_DEF = 4;

    localparam logic [10:0] SDO_BASE_RESET = 11'h580;
    localparam logic [15:0] SDO_POS_INDEX  = 16'h6064;
    localparam logic [10:0] PDO_STATUS     = 11'h180;
    localparam logic [10:0] PDO_STAT_POS   = 11'h280;
    localparam logic [10:0] PDO_POS_VEL    = 11'h380;
    localparam logic [10:0] PDO_POS        = 11'h480;
    localparam logic [10:0] NODE_MASK      = 11'h00f;

    localparam logic [1:0] CFG_NODE_IDS = 2'd0;
    localparam logic [1:0] CFG_ENABLE   = 2'd1;
    localparam logic [1:0] CFG_REVERSED = 2'd2;
    localparam logic [1:0] CFG_SDO_BASE = 2'd3;

    typedef logic [7:0][7:0] t_data;

    typedef enum logic [2:0] {
        K_NONE,
        K_SDO_POS,
        K_STATUS,
        K_STAT_POS,
        K_POS_VEL,
        K_POS
    } t_kind;

    typedef struct packed {
        logic [15:0] node_ids;
        logic [3:0]  enable;
        logic [3:0]  reversed;
        logic [10:0] sdo_base;
    } t_cfg;

    typedef struct packed {
        logic        hit;
        logic [1:0]  slot;
        logic        wr_status;
        logic        wr_pos;
        logic        wr_speed;
        logic [4:0]  status;
        logic [31:0] pos;
        logic [31:0] spd;
    } t_upd;

    typedef struct packed {
        logic [4:0]  status;
        logic [31:0] pos;
        logic [31:0] spd;
        logic        bwd;
    } t_view;

    // Status word bits 0, 2, 3, 5 and 10 packed low to high.
    function automatic logic [4:0] decode_status(input logic [15:0] sw);
        return {sw[10], sw[5], sw[3], sw[2], sw[0]};
    endfunction

endpackage

// File: rtl/core/canopen_servo_feedback_decoder_top.sv
// A frame is held in an input register, then slot match and decode write its report into
// the output register. Throughput: one frame per cycle while i_out_ready does not stall the
// output; the output register lets the next frame enter while a report waits. Synchronous
// active-low reset clears the handshake state, the per-slot status, position, speed and
// direction, and the configuration, with the SDO base set to 11'h580 instead of zero.
module canopen_servo_feedback_decoder_top
    import cosfd_pkg::*;
#(
    parameter int MOTOR_SLOTS = MOTOR_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [10:0]        i_frame_id,
    input  logic [7:0]         i_byte0,
    input  logic [7:0]         i_byte1,
    input  logic [7:0]         i_byte2,
    input  logic [7:0]         i_byte3,
    input  logic [7:0]         i_byte4,
    input  logic [7:0]         i_byte5,
    input  logic [7:0]         i_byte6,
    input  logic [7:0]         i_byte7,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_hit,
    output logic [1:0]         o_slot,
    output logic               o_servo_ready,
    output logic               o_servo_on,
    output logic               o_fault,
    output logic               o_quick_stop,
    output logic               o_in_position,
    output logic signed [31:0] o_position,
    output logic signed [31:0] o_speed,
    output logic               o_backward
);

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic [10:0] r_frame_id;
    t_data       r_data;
    logic        r_out_valid;
    logic        r_hit;
    logic [1:0]  r_slot;
    logic [4:0]  r_status;
    logic [31:0] r_pos;
    logic [31:0] r_spd;
    logic        r_bwd;

    logic        adv;
    logic        commit;
    t_upd        upd;
    t_view       view;

    assign o_cfg_ready = 1'b1;
    assign adv         = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || adv;
    assign commit      = r_in_valid && adv;

    cosfd_frame_decode #(
        .MOTOR_SLOTS(MOTOR_SLOTS)
    ) u_decode (
        .i_frame_id(r_frame_id),
        .i_data    (r_data),
        .i_cfg     (r_cfg),
        .o_upd     (upd)
    );

    cosfd_slot_bank #(
        .MOTOR_SLOTS(MOTOR_SLOTS)
    ) u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_commit(commit),
        .i_upd   (upd),
        .o_view  (view)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_cfg.node_ids <= '0;
            r_cfg.enable   <= '0;
            r_cfg.reversed <= '0;
            r_cfg.sdo_base <= SDO_BASE_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_NODE_IDS: r_cfg.node_ids <= i_cfg_data;
                    CFG_ENABLE:   r_cfg.enable   <= i_cfg_data[3:0];
                    CFG_REVERSED: r_cfg.reversed <= i_cfg_data[3:0];
                    CFG_SDO_BASE: r_cfg.sdo_base <= i_cfg_data[10:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_frame_id <= i_frame_id;
            r_data     <= {i_byte7, i_byte6, i_byte5, i_byte4,
                           i_byte3, i_byte2, i_byte1, i_byte0};
        end
        // A miss reports all fields as zero.
        if (commit) begin
            r_hit    <= upd.hit;
            r_slot   <= upd.hit ? upd.slot    : '0;
            r_status <= upd.hit ? view.status : '0;
            r_pos    <= upd.hit ? view.pos    : '0;
            r_spd    <= upd.hit ? view.spd    : '0;
            r_bwd    <= upd.hit ? view.bwd    : 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_slot        = r_slot;
    assign o_servo_ready = r_status[0];
    assign o_servo_on    = r_status[1];
    assign o_fault       = r_status[2];
    assign o_quick_stop  = r_status[3];
    assign o_in_position = r_status[4];
    assign o_position    = r_pos;
    assign o_speed       = r_spd;
    assign o_backward    = r_bwd;

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> (o_slot == 2'd0 && o_position == 32'sd0 &&
                                   o_speed == 32'sd0 && !o_backward))
        else $error("miss report carries nonzero fields");

    a_dir_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> (o_backward == o_speed[31]))
        else $error("direction flag disagrees with stored speed sign");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> (32'(o_slot) < MOTOR_SLOTS))
        else $error("reported slot beyond configured slot count");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_frame_id))
        else $error("stalled request lost from input stage");

endmodule

// File: rtl/core/cosfd_frame_decode.sv
module cosfd_frame_decode
    import cosfd_pkg::*;
#(
    parameter int MOTOR_SLOTS = MOTOR_SLOTS_DEF
) (
    input  logic [10:0] i_frame_id,
    input  t_data       i_data,
    input  t_cfg        i_cfg,
    output t_upd        o_upd
);

    logic [3:0]  node;
    logic [10:0] base;
    logic        found;
    logic [1:0]  s;
    logic        rev;
    t_kind       kind;
    logic [31:0] raw_pos;
    logic [31:0] raw_spd;
    logic [15:0] sw;

    assign node = i_frame_id[3:0];
    assign base = i_frame_id & ~NODE_MASK;
    assign sw   = {i_data[1], i_data[0]};

    // Walk from the top slot down so that the lowest matching slot wins.
    always_comb begin
        found = 1'b0;
        s     = '0;
        for (int k = MOTOR_SLOTS - 1; k >= 0; k--) begin
            if (i_cfg.enable[k] && i_cfg.node_ids[4*k +: 4] == node) begin
                found = 1'b1;
                s     = 2'(k);
            end
        end
    end

    always_comb begin
        kind = K_NONE;
        if (base == (i_cfg.sdo_base & ~NODE_MASK)) begin
            if ({i_data[2], i_data[1]} == SDO_POS_INDEX) begin
                kind = K_SDO_POS;
            end
        end else if (base == PDO_STATUS) begin
            kind = K_STATUS;
        end else if (base == PDO_STAT_POS) begin
            kind = K_STAT_POS;
        end else if (base == PDO_POS_VEL) begin
            kind = K_POS_VEL;
        end else if (base == PDO_POS) begin
            kind = K_POS;
        end
    end

    assign rev = i_cfg.reversed[s];

    always_comb begin
        o_upd           = '0;
        raw_pos         = {i_data[3], i_data[2], i_data[1], i_data[0]};
        raw_spd         = {i_data[7], i_data[6], i_data[5], i_data[4]};
        o_upd.slot      = s;
        o_upd.status    = decode_status(sw);
        unique case (kind)
            K_SDO_POS: begin
                raw_pos      = {i_data[7], i_data[6], i_data[5], i_data[4]};
                o_upd.wr_pos = 1'b1;
            end
            K_STATUS: begin
                o_upd.wr_status = 1'b1;
            end
            K_STAT_POS: begin
                raw_pos         = {i_data[5], i_data[4], i_data[3], i_data[2]};
                o_upd.wr_status = 1'b1;
                o_upd.wr_pos    = 1'b1;
            end
            K_POS_VEL: begin
                o_upd.wr_pos   = 1'b1;
                o_upd.wr_speed = 1'b1;
            end
            K_POS: begin
                o_upd.wr_pos = 1'b1;
            end
            default: begin
            end
        endcase
        o_upd.hit = found && (kind != K_NONE);
        // Negation wraps, so the most negative value maps onto itself.
        o_upd.pos = rev ? (32'd0 - raw_pos) : raw_pos;
        o_upd.spd = rev ? (32'd0 - raw_spd) : raw_spd;
    end

endmodule

// File: rtl/core/cosfd_slot_bank.sv
module cosfd_slot_bank
    import cosfd_pkg::*;
#(
    parameter int MOTOR_SLOTS = MOTOR_SLOTS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_commit,
    input  t_upd  i_upd,
    output t_view o_view
);

    logic [4:0]  r_status [MOTOR_SLOTS];
    logic [31:0] r_pos    [MOTOR_SLOTS];
    logic [31:0] r_spd    [MOTOR_SLOTS];
    logic        r_bwd    [MOTOR_SLOTS];
    logic [4:0]  n_status [MOTOR_SLOTS];
    logic [31:0] n_pos    [MOTOR_SLOTS];
    logic [31:0] n_spd    [MOTOR_SLOTS];
    logic        n_bwd    [MOTOR_SLOTS];

    always_comb begin
        o_view = '0;
        for (int k = 0; k < MOTOR_SLOTS; k++) begin
            n_status[k] = r_status[k];
            n_pos[k]    = r_pos[k];
            n_spd[k]    = r_spd[k];
            n_bwd[k]    = r_bwd[k];
            if (i_commit && i_upd.hit && i_upd.slot == 2'(k)) begin
                if (i_upd.wr_status) begin
                    n_status[k] = i_upd.status;
                end
                if (i_upd.wr_pos) begin
                    n_pos[k] = i_upd.pos;
                end
                if (i_upd.wr_speed) begin
                    n_spd[k] = i_upd.spd;
                    n_bwd[k] = i_upd.spd[31];
                end
            end
            // The report shows the slot's values after this frame's update.
            if (i_upd.slot == 2'(k)) begin
                o_view.status = n_status[k];
                o_view.pos    = n_pos[k];
                o_view.spd    = n_spd[k];
                o_view.bwd    = n_bwd[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MOTOR_SLOTS; k++) begin
                r_status[k] <= '0;
                r_pos[k]    <= '0;
                r_spd[k]    <= '0;
                r_bwd[k]    <= 1'b0;
            end
        end else begin
            for (int k = 0; k < MOTOR_SLOTS; k++) begin
                r_status[k] <= n_status[k];
                r_pos[k]    <= n_pos[k];
                r_spd[k]    <= n_spd[k];
                r_bwd[k]    <= n_bwd[k];
            end
        end
    end

endmodule
